// ----- design/dkas_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dkas_pkg;

	// Default sizes of the sorter.
	localparam int MAX_ITEMS_DEF = 64;
	localparam int KEY_WIDTH_DEF = 32;

	// Fixed field widths on the stream ports.
	localparam int IN_KEY_W    = 32;
	localparam int POS_W       = 6;
	localparam int OUT_TDATA_W = 8;

	// Controller phases: taking keys in, or unloading the sorted run.
	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} dkas_state_t;

	// Command broadcast from the controller to every cell.
	typedef struct packed {
		logic load;
		logic drain;
	} dkas_cmd_t;

endpackage

`default_nettype wire

// ----- design/dkas_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dkas_cell #(
	parameter int KW = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire dkas_pkg::dkas_cmd_t      cmd,
	input  wire logic [KW-1:0]            new_key,
	input  wire logic [dkas_pkg::POS_W-1:0] new_pos,
	input  wire logic                     prev_ge,
	input  wire logic                     prev_valid,
	input  wire logic [KW-1:0]            prev_key,
	input  wire logic [dkas_pkg::POS_W-1:0] prev_pos,
	input  wire logic                     next_valid,
	input  wire logic [KW-1:0]            next_key,
	input  wire logic [dkas_pkg::POS_W-1:0] next_pos,
	output logic                          ge,
	output logic                          valid,
	output logic [KW-1:0]                 key,
	output logic [dkas_pkg::POS_W-1:0]    pos
);
	import dkas_pkg::*;

	logic             valid_q;
	logic [KW-1:0]    key_q;
	logic [POS_W-1:0] pos_q;

	// A held key that is greater or equal stays put; ties keep arrival order.
	assign ge    = valid_q && ($signed(key_q) >= $signed(new_key));
	assign valid = valid_q;
	assign key   = key_q;
	assign pos   = pos_q;

	// Occupancy grows from the head on a load and shrinks from the tail on a drain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.load) begin
			valid_q <= prev_valid;
		end else if (cmd.drain) begin
			valid_q <= next_valid;
		end
	end

	// Hold, insert here, take the left neighbor's entry, or take the right neighbor's on unload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (!ge) begin
				if (prev_ge) begin
					key_q <= new_key;
					pos_q <= new_pos;
				end else begin
					key_q <= prev_key;
					pos_q <= prev_pos;
				end
			end
		end else if (cmd.drain) begin
			key_q <= next_key;
			pos_q <= next_pos;
		end
	end

endmodule

`default_nettype wire

// ----- design/dkas_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dkas_ctrl #(
	parameter int MAX_ITEMS = dkas_pkg::MAX_ITEMS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	input  wire logic                   s_tlast,
	output logic                        s_tready,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic                        m_tlast,
	output dkas_pkg::dkas_cmd_t         cmd,
	output logic [dkas_pkg::POS_W-1:0]  new_pos
);
	import dkas_pkg::*;

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	dkas_state_t      state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             in_acc, out_acc, final_key;

	assign in_acc    = s_tvalid && s_tready;
	assign out_acc   = m_tvalid && m_tready;
	// A key that fills the chain closes the set even without tlast.
	assign final_key = s_tlast || (cnt_q == CNT_W'(MAX_ITEMS - 1));
	assign new_pos   = POS_W'(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Count keys up while loading and down while unloading. The input is always
	// ready while loading and the output always valid while unloading, so the
	// handshake reduces to the other side's signal in each phase.
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		s_tready  = 1'b0;
		m_tvalid  = 1'b0;
		m_tlast   = 1'b0;
		cmd.load  = 1'b0;
		cmd.drain = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
				if (s_tvalid) begin
					cnt_d = cnt_q + CNT_W'(1);
					if (final_key) begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				m_tvalid  = 1'b1;
				m_tlast   = (cnt_q == CNT_W'(1));
				cmd.drain = m_tready;
				if (m_tready) begin
					cnt_d = cnt_q - CNT_W'(1);
					if (m_tlast) begin
						state_d = ST_LOAD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// Loading and unloading never overlap.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input and output both open");

	// The final key of a set starts the unload in the next cycle.
	a_final_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && final_key) |=> (m_tvalid && !s_tready))
		else $error("final key did not start unload");

	// The end of the run leaves an empty chain ready for the next set.
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && m_tlast) |=> (s_tready && cnt_q == '0))
		else $error("unload did not end empty");

	// The count never passes the chain length.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ITEMS))
		else $error("key count out of range");

endmodule

`default_nettype wire

// ----- design/descending_key_argsort_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Descending-key argsort. Keys of a set arrive on the s_ side one word per cycle, each
// tagged by its arrival position; s_tlast marks the final key, and a key that fills all
// MAX_ITEMS cells closes the set as well. Each key is placed on arrival by a chain of
// MAX_ITEMS cells that compare it against their held key in parallel and shift the
// smaller entries one place down. After the final key the chain unloads from its head,
// one word per cycle while m_tready is high: the arrival positions in descending key
// order, equal keys lower position first, with m_tlast on the smallest key. No key is
// taken while a set is unloading. Keys are compared as signed values over their low
// min(KEY_WIDTH, 32) bits.
module descending_key_argsort_core #(
	parameter int MAX_ITEMS = dkas_pkg::MAX_ITEMS_DEF,
	parameter int KEY_WIDTH = dkas_pkg::KEY_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [dkas_pkg::IN_KEY_W-1:0]    s_tdata,  // [31:0] key
	input  wire logic                             s_tlast,  // last_key
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [dkas_pkg::OUT_TDATA_W-1:0]      m_tdata,  // [5:0] position, rest zero
	output logic                                  m_tlast   // last_rank
);
	import dkas_pkg::*;

	localparam int KW = (KEY_WIDTH > IN_KEY_W) ? IN_KEY_W : KEY_WIDTH;

	dkas_cmd_t        cmd;
	logic [POS_W-1:0] new_pos;
	logic [KW-1:0]    new_key;

	logic             ge    [MAX_ITEMS];
	logic             valid [MAX_ITEMS];
	logic [KW-1:0]    key   [MAX_ITEMS];
	logic [POS_W-1:0] pos   [MAX_ITEMS];

	assign new_key = s_tdata[KW-1:0];

	dkas_ctrl #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tlast (s_tlast),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tlast (m_tlast),
		.cmd     (cmd),
		.new_pos (new_pos)
	);

	// The insertion chain; the head cell always holds the largest key.
	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic             p_ge, p_valid, n_valid;
		logic [KW-1:0]    p_key, n_key;
		logic [POS_W-1:0] p_pos, n_pos;

		if (i == 0) begin : g_head
			assign p_ge    = 1'b1;
			assign p_valid = 1'b1;
			assign p_key   = '0;
			assign p_pos   = '0;
		end else begin : g_body
			assign p_ge    = ge[i-1];
			assign p_valid = valid[i-1];
			assign p_key   = key[i-1];
			assign p_pos   = pos[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_tail
			assign n_valid = 1'b0;
			assign n_key   = '0;
			assign n_pos   = '0;
		end else begin : g_next
			assign n_valid = valid[i+1];
			assign n_key   = key[i+1];
			assign n_pos   = pos[i+1];
		end

		dkas_cell #(
			.KW(KW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.new_key   (new_key),
			.new_pos   (new_pos),
			.prev_ge   (p_ge),
			.prev_valid(p_valid),
			.prev_key  (p_key),
			.prev_pos  (p_pos),
			.next_valid(n_valid),
			.next_key  (n_key),
			.next_pos  (n_pos),
			.ge        (ge[i]),
			.valid     (valid[i]),
			.key       (key[i]),
			.pos       (pos[i])
		);
	end

	// Results leave from the head cell.
	assign m_tdata = {{(OUT_TDATA_W - POS_W){1'b0}}, pos[0]};

endmodule

`default_nettype wire
